/* rtl/core/tlma_pkg.sv */
// Shared constants, types and helpers for the tabu list match-and-age block.
// No dependencies; every other file of the block but tlma_ram imports this package.
`default_nettype none

package tlma_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int MAX_DIMS      = 8;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int COMP_W = 32;
    localparam int DIMS_W = 4;
    localparam int TEN_W  = 8;
    localparam int LIVE_W = 5;
    localparam int ACT_W  = 2;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [DIMS_W-1:0] DIMS_RST   = 4'd2;
    localparam logic [TEN_W-1:0]  TENURE_RST = 8'd10;

    // Register index, taken from paddr[2]
    localparam logic REG_DIMS   = 1'b0;
    localparam logic REG_TENURE = 1'b1;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_LFLUSH,
        S_INS,
        S_TICK,
        S_DONE
    } t_state;

    // Sequencer to lanes and merge stage
    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] addr;
        logic             wr_en;
        logic             rd_live;
    } t_lane_ctl;

    // Lanes that take part in a compare: zero counts as one, saturate at MAX_DIMS
    function automatic logic [MAX_DIMS-1:0] lane_mask(input logic [DIMS_W-1:0] dims);
        int                  eff;
        logic [MAX_DIMS-1:0] m;
        eff = int'(dims);
        if (eff == 0) eff = 1;
        if (eff > MAX_DIMS) eff = MAX_DIMS;
        for (int d = 0; d < MAX_DIMS; d++) begin
            m[d] = (d < eff);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/tabu_list_match_and_age.sv */
// Tabu list top level: APB registers, component lanes, merge stage, sequencer.
// Lookup sweeps every slot and then flushes the last read; insert stops at the first
// free slot, found by a one-slot-a-cycle sweep; tick sweeps every slot. Insert into a
// full table and unused action code 3 skip the sweep and go straight to the result.
// One item at a time: next transfer the cycle after the result is loaded; the sweep
// over the per-lane RAM read port sets it. Reset (synchronous): table emptied at once,
// dims_in_use 2, tenure_ticks 10.
`default_nettype none

module tabu_list_match_and_age import tlma_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [ACT_W-1:0]         i_action,
    input  wire logic signed [COMP_W-1:0] i_move_c0,
    input  wire logic signed [COMP_W-1:0] i_move_c1,
    input  wire logic signed [COMP_W-1:0] i_move_c2,
    input  wire logic signed [COMP_W-1:0] i_move_c3,
    input  wire logic signed [COMP_W-1:0] i_move_c4,
    input  wire logic signed [COMP_W-1:0] i_move_c5,
    input  wire logic signed [COMP_W-1:0] i_move_c6,
    input  wire logic signed [COMP_W-1:0] i_move_c7,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic                          o_is_tabu,
    output logic                          o_insert_accepted,
    output logic [LIVE_W-1:0]             o_live_entries,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_AW-1:0]        paddr,
    input  wire logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]             prdata,
    output logic                          pready
);

    logic [DIMS_W-1:0]        r_dims;
    logic [TEN_W-1:0]         r_tenure_ticks;
    logic                     w_cfg_wr;
    t_lane_ctl                w_ctl;
    logic [MAX_DIMS-1:0]      w_eq;
    logic                     w_hit;
    logic signed [COMP_W-1:0] w_move [MAX_DIMS];

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims         <= DIMS_RST;
            r_tenure_ticks <= TENURE_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_DIMS:   r_dims         <= pwdata[DIMS_W-1:0];
                REG_TENURE: r_tenure_ticks <= pwdata[TEN_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DIMS:   prdata = APB_DW'(r_dims);
            REG_TENURE: prdata = APB_DW'(r_tenure_ticks);
        endcase
    end

    assign w_move[0] = i_move_c0;
    assign w_move[1] = i_move_c1;
    assign w_move[2] = i_move_c2;
    assign w_move[3] = i_move_c3;
    assign w_move[4] = i_move_c4;
    assign w_move[5] = i_move_c5;
    assign w_move[6] = i_move_c6;
    assign w_move[7] = i_move_c7;

    tlma_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_action          (i_action),
        .o_in_stall        (o_in_stall),
        .i_tenure_ticks    (r_tenure_ticks),
        .i_hit             (w_hit),
        .o_ctl             (w_ctl),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_is_tabu         (o_is_tabu),
        .o_insert_accepted (o_insert_accepted),
        .o_live_entries    (o_live_entries)
    );

    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
        tlma_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_move (w_move[d]),
            .o_eq   (w_eq[d])
        );
    end

    tlma_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_dims  (r_dims),
        .i_eq    (w_eq),
        .o_hit   (w_hit)
    );

endmodule

`default_nettype wire

/* rtl/core/tlma_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module tlma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/tlma_lane.sv */
// One component lane: holds the item's component, stores it per slot and
// compares the stored word of the addressed slot. Uses tlma_pkg and tlma_ram.
`default_nettype none

module tlma_lane import tlma_pkg::*; (
    input  wire logic                     i_clk,
    input  wire t_lane_ctl                i_ctl,
    input  wire logic signed [COMP_W-1:0] i_move,
    output logic                          o_eq
);

    logic signed [COMP_W-1:0] r_move;
    logic        [COMP_W-1:0] w_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_move <= i_move;
        end
    end

    tlma_ram #(
        .WIDTH (COMP_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr_en),
        .i_waddr (i_ctl.addr),
        .i_wdata ($unsigned(r_move)),
        .i_raddr (i_ctl.addr),
        .o_rdata (w_rdata)
    );

    // Read data is registered and follows the address in the next cycle; r_move holds for the whole item
    assign o_eq = (w_rdata == $unsigned(r_move));

endmodule

`default_nettype wire

/* rtl/core/tlma_merge.sv */
// Merge stage: combines the lane compares of one slot under the dims mask
// and accumulates the lookup hit. Uses tlma_pkg.
`default_nettype none

module tlma_merge import tlma_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_lane_ctl           i_ctl,
    input  wire logic [DIMS_W-1:0]   i_dims,
    input  wire logic [MAX_DIMS-1:0] i_eq,
    output logic                     o_hit
);

    logic                r_cmp_live;
    logic                r_hit;
    logic [MAX_DIMS-1:0] w_mask;
    logic                w_entry_hit;

    assign w_mask      = lane_mask(i_dims);
    assign w_entry_hit = r_cmp_live && (&(i_eq | ~w_mask));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_live <= 1'b0;
            r_hit      <= 1'b0;
        end else begin
            // align slot liveness with the registered RAM read
            r_cmp_live <= i_ctl.rd_live;
            if (i_ctl.load) begin
                r_hit <= 1'b0;
            end else if (w_entry_hit) begin
                r_hit <= 1'b1;
            end
        end
    end

    assign o_hit = r_hit;

endmodule

`default_nettype wire

/* rtl/core/tlma_ctrl.sv */
// Sequencer: slot sweep, valid bits, tenures, live count and result register.
// Uses tlma_pkg; drives the lanes and the merge stage.
`default_nettype none

module tlma_ctrl import tlma_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [ACT_W-1:0]  i_action,
    output logic                   o_in_stall,
    input  wire logic [TEN_W-1:0]  i_tenure_ticks,
    input  wire logic              i_hit,
    output t_lane_ctl              o_ctl,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_is_tabu,
    output logic                   o_insert_accepted,
    output logic [LIVE_W-1:0]      o_live_entries
);

    t_state                   r_state, n_state;
    t_action                  r_action, n_action;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [TEN_W-1:0]         r_tenure [TABLE_ENTRIES];
    logic [TEN_W-1:0]         n_tenure [TABLE_ENTRIES];
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_ins_ok, n_ins_ok;
    logic                     r_out_valid, n_out_valid;
    logic                     r_out_tabu, n_out_tabu;
    logic                     r_out_acc, n_out_acc;
    logic [LIVE_W-1:0]        r_out_live, n_out_live;

    logic w_accept;
    logic w_last;
    logic w_full;
    logic w_slot_live;
    logic w_out_free;
    logic w_load_out;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_last      = (r_idx == IDX_W'(TABLE_ENTRIES - 1));
    assign w_full      = (r_count == CNT_W'(TABLE_ENTRIES));
    assign w_slot_live = r_valid[r_idx];
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_load_out  = (r_state == S_DONE) && w_out_free;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_action'(i_action))
                        ACT_LOOKUP: n_state = S_LOOK;
                        ACT_INSERT: n_state = w_full ? S_DONE : S_INS;
                        ACT_TICK:   n_state = S_TICK;
                        ACT_NOP:    n_state = S_DONE;
                    endcase
                end
            end
            S_LOOK: begin
                if (w_last) n_state = S_LFLUSH;
            end
            S_LFLUSH: begin
                n_state = S_DONE;
            end
            S_INS: begin
                if (!w_slot_live || w_last) n_state = S_DONE;
            end
            S_TICK: begin
                if (w_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs towards the input side, lanes and merge stage
    always_comb begin
        o_in_stall    = (r_state != S_IDLE);
        o_ctl.load    = w_accept;
        o_ctl.addr    = r_idx;
        o_ctl.wr_en   = (r_state == S_INS) && !w_slot_live;
        o_ctl.rd_live = (r_state == S_LOOK) && w_slot_live;
    end

    // Table and result datapath
    always_comb begin
        n_action    = r_action;
        n_idx       = r_idx;
        n_valid     = r_valid;
        n_tenure    = r_tenure;
        n_count     = r_count;
        n_ins_ok    = r_ins_ok;
        n_out_valid = r_out_valid;
        n_out_tabu  = r_out_tabu;
        n_out_acc   = r_out_acc;
        n_out_live  = r_out_live;

        if (w_accept) begin
            n_action = t_action'(i_action);
            n_idx    = '0;
            n_ins_ok = 1'b0;
        end

        if (r_state == S_LOOK || r_state == S_INS || r_state == S_TICK) begin
            n_idx = r_idx + IDX_W'(1);
        end

        // take the first free slot
        if (r_state == S_INS && !w_slot_live) begin
            n_valid[r_idx]  = 1'b1;
            n_tenure[r_idx] = i_tenure_ticks;
            n_count         = r_count + CNT_W'(1);
            n_ins_ok        = 1'b1;
        end

        // age one slot per cycle; drop it when its tenure runs out
        if (r_state == S_TICK && w_slot_live) begin
            if (r_tenure[r_idx] <= TEN_W'(1)) begin
                n_valid[r_idx]  = 1'b0;
                n_tenure[r_idx] = '0;
                n_count         = r_count - CNT_W'(1);
            end else begin
                n_tenure[r_idx] = r_tenure[r_idx] - TEN_W'(1);
            end
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (w_load_out) begin
            n_out_valid = 1'b1;
            n_out_tabu  = (r_action == ACT_LOOKUP) && i_hit;
            n_out_acc   = r_ins_ok;
            n_out_live  = LIVE_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_action    <= ACT_NOP;
            r_idx       <= '0;
            r_valid     <= '0;
            r_tenure    <= '{default: '0};
            r_count     <= '0;
            r_ins_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_action    <= n_action;
            r_idx       <= n_idx;
            r_valid     <= n_valid;
            r_tenure    <= n_tenure;
            r_count     <= n_count;
            r_ins_ok    <= n_ins_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_tabu <= n_out_tabu;
        r_out_acc  <= n_out_acc;
        r_out_live <= n_out_live;
    end

    assign o_out_valid       = r_out_valid;
    assign o_is_tabu         = r_out_tabu;
    assign o_insert_accepted = r_out_acc;
    assign o_live_entries    = r_out_live;

endmodule

`default_nettype wire

/* rtl/core/tlma_checker.sv */
// Port-level checks for the tabu list top level, attached by bind.
// Uses tlma_pkg; watches only tabu_list_match_and_age ports.
`default_nettype none

module tlma_checker import tlma_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic              o_is_tabu,
    input wire logic              o_insert_accepted,
    input wire logic [LIVE_W-1:0] o_live_entries
);

    // One item at a time: a transfer closes the input side at once
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is at work");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_tabu && o_insert_accepted))
        else $error("lookup and insert flags both set");

    // A hit or a stored insert means at least one live entry
    a_flag_needs_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_is_tabu || o_insert_accepted)) |-> (o_live_entries != '0))
        else $error("flag set with an empty table");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_is_tabu) && $stable(o_insert_accepted)
             && $stable(o_live_entries)))
        else $error("stalled result changed");

endmodule

bind tabu_list_match_and_age tlma_checker u_tlma_checker (.*);

`default_nettype wire
